// ----- design/framed_decimal_field_parser_unit_assert.svh -----
// Assertion macros shared by the parser modules.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef FRAMED_DECIMAL_FIELD_PARSER_UNIT_ASSERT_SVH
`define FRAMED_DECIMAL_FIELD_PARSER_UNIT_ASSERT_SVH

// Condition that must hold at every edge.
`define FDFP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define FDFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fdfp_pkg.sv -----
package fdfp_pkg;

    localparam int MAX_FRAME_CHARS_DEF = 32;
    localparam int NUM_FIELDS          = 6;
    localparam int VALUE_W             = 16;
    localparam int ACC_W               = 17;
    localparam int FIELD_IDX_W         = 3;

    localparam logic [FIELD_IDX_W-1:0] LAST_FIELD = FIELD_IDX_W'(NUM_FIELDS - 1);
    localparam logic [ACC_W-1:0]       MAG_LIMIT  = 17'd32768;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_START     = 2'd0;
    localparam logic [1:0] REG_END       = 2'd1;
    localparam logic [1:0] REG_SEPARATOR = 2'd2;

    localparam logic [7:0] START_CHAR_RST     = 8'd83;  // 'S'
    localparam logic [7:0] END_CHAR_RST       = 8'd69;  // 'E'
    localparam logic [7:0] SEPARATOR_CHAR_RST = 8'd38;  // '&'

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,   // skipping blanks, sign allowed
        PH_DIGITS = 2'd1,   // collecting digits
        PH_DONE   = 2'd2    // field ended, ignore until separator
    } phase_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] separator_char;
    } fdfp_cfg_t;

    typedef struct packed {
        logic                                malformed;
        logic [NUM_FIELDS-1:0][VALUE_W-1:0]  values;
    } fdfp_result_t;

    // Saturate the magnitude and apply the sign.
    function automatic logic [VALUE_W-1:0] current_value(input logic neg,
                                                         input logic [ACC_W-1:0] mag);
        logic [ACC_W-1:0] m;
        m = mag;
        if (neg)
        begin
            if (m > MAG_LIMIT)
            begin
                m = MAG_LIMIT;
            end
            return VALUE_W'(17'd0 - m);
        end
        if (m > 17'd32767)
        begin
            m = 17'd32767;
        end
        return m[VALUE_W-1:0];
    endfunction

endpackage

// ----- design/fdfp_core.sv -----
`include "framed_decimal_field_parser_unit_assert.svh"

module fdfp_core
    import fdfp_pkg::*;
#(
    parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,        // a byte request is accepted this cycle
    input  logic [7:0]   byte_in,
    input  fdfp_cfg_t    cfg,
    output logic         res_valid,
    output fdfp_result_t res
);

    localparam int KW = $clog2(MAX_FRAME_CHARS);
    localparam logic [KW-1:0] KEPT_LIMIT = KW'(MAX_FRAME_CHARS - 1);

    logic                               frame_open_reg, frame_open_next;
    logic [KW-1:0]                      kept_count_reg, kept_count_next;
    logic [FIELD_IDX_W-1:0]             field_number_reg, field_number_next;
    phase_t                             phase_reg, phase_next;
    logic                               negative_reg, negative_next;
    logic [ACC_W-1:0]                   acc_reg, acc_next;
    logic [NUM_FIELDS-1:0][VALUE_W-1:0] captured_reg, captured_next;

    logic               is_start, is_end, is_sep, is_digit, is_blank, is_sign;
    logic [VALUE_W-1:0] cur_value;
    logic [3:0]         digit_val;
    logic [18:0]        acc_wide, acc_sum;

    assign is_start  = (byte_in == cfg.start_char);
    assign is_end    = (byte_in == cfg.end_char);
    assign is_sep    = (byte_in == cfg.separator_char);
    assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign is_blank  = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
    assign is_sign   = (byte_in == CH_PLUS) || (byte_in == CH_MINUS);
    assign digit_val = 4'(byte_in - CH_ZERO);
    assign cur_value = current_value(negative_reg, acc_reg);

    // acc * 10 + digit as two shifts and two adds
    assign acc_wide = {2'b00, acc_reg};
    assign acc_sum  = (acc_wide << 3) + (acc_wide << 1) + 19'(digit_val);

    // Next state
    always_comb
    begin
        frame_open_next   = frame_open_reg;
        kept_count_next   = kept_count_reg;
        field_number_next = field_number_reg;
        phase_next        = phase_reg;
        negative_next     = negative_reg;
        acc_next          = acc_reg;
        captured_next     = captured_reg;

        if (take)
        begin
            priority if (is_start)
            begin
                frame_open_next   = 1'b1;
                kept_count_next   = '0;
                field_number_next = '0;
                phase_next        = PH_LEAD;
                negative_next     = 1'b0;
                acc_next          = '0;
                captured_next     = '0;
            end
            else if (!frame_open_reg)
            begin
                // drop bytes outside a frame
            end
            else if (is_end)
            begin
                frame_open_next   = 1'b0;
                kept_count_next   = '0;
                field_number_next = '0;
                phase_next        = PH_LEAD;
                negative_next     = 1'b0;
                acc_next          = '0;
            end
            else if (kept_count_reg < KEPT_LIMIT)
            begin
                kept_count_next = kept_count_reg + 1'b1;
                if (is_sep)
                begin
                    if (field_number_reg < LAST_FIELD)
                    begin
                        for (int k = 0; k < NUM_FIELDS; k++)
                        begin
                            if (field_number_reg == FIELD_IDX_W'(k))
                            begin
                                captured_next[k] = cur_value;
                            end
                        end
                        field_number_next = field_number_reg + 1'b1;
                        phase_next        = PH_LEAD;
                        negative_next     = 1'b0;
                        acc_next          = '0;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_LEAD:
                        begin
                            priority if (is_blank)
                            begin
                                phase_next = PH_LEAD;
                            end
                            else if (is_sign)
                            begin
                                negative_next = (byte_in == CH_MINUS);
                                phase_next    = PH_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                acc_next   = ACC_W'(digit_val);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                acc_next = (acc_sum > 19'(MAG_LIMIT)) ? MAG_LIMIT
                                                                      : acc_sum[ACC_W-1:0];
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DONE:
                        begin
                            phase_next = PH_DONE;
                        end
                        default:
                        begin
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
            else
            begin
                // drop bytes beyond the kept-character limit
            end
        end
    end

    // Result on a closing byte
    always_comb
    begin
        res_valid     = take && !is_start && frame_open_reg && is_end;
        res.malformed = (field_number_reg < LAST_FIELD);
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            if (FIELD_IDX_W'(k) < field_number_reg)
            begin
                res.values[k] = captured_reg[k];
            end
            else if (FIELD_IDX_W'(k) == field_number_reg)
            begin
                res.values[k] = cur_value;
            end
            else
            begin
                res.values[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg   <= 1'b0;
            kept_count_reg   <= '0;
            field_number_reg <= '0;
            phase_reg        <= PH_LEAD;
            negative_reg     <= 1'b0;
            acc_reg          <= '0;
            captured_reg     <= '0;
        end
        else
        begin
            frame_open_reg   <= frame_open_next;
            kept_count_reg   <= kept_count_next;
            field_number_reg <= field_number_next;
            phase_reg        <= phase_next;
            negative_reg     <= negative_next;
            acc_reg          <= acc_next;
            captured_reg     <= captured_next;
        end
    end

    `FDFP_ASSERT_ALWAYS(a_field_range, field_number_reg <= LAST_FIELD, "field index out of range")
    `FDFP_ASSERT_ALWAYS(a_acc_limit, acc_reg <= MAG_LIMIT, "magnitude above saturation limit")
    `FDFP_ASSERT_ALWAYS(a_closed_idle,
        frame_open_reg || (kept_count_reg == '0 && field_number_reg == '0 && phase_reg == PH_LEAD),
        "parse state not cleared outside a frame")

endmodule

// ----- design/framed_decimal_field_parser_unit.sv -----
// A closing byte's result is registered into the output register, or into the skid slot while that waits.
// Throughput: one byte per cycle while the skid slot is free; the parse state updates in a single registered step.
// A two-deep result buffer (output register plus skid) keeps input flowing while a result waits.
// Reset (rst_n, async, active low): no frame open, buffers empty, characters back to S, E, &.
`include "framed_decimal_field_parser_unit_assert.svh"

module framed_decimal_field_parser_unit
    import fdfp_pkg::*;
#(
    parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,    // [7:0] byte_in

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] interval_value, [31:16] left_wall_value, [47:32] right_wall_value,
    // [63:48] left_range_value, [79:64] front_range_value, [95:80] right_range_value,
    // [96] malformed, [103:97] zero
    output logic [103:0] m_axis_tdata,

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    fdfp_cfg_t    cfg_reg;
    fdfp_result_t res;
    logic         res_valid;
    logic         take;

    fdfp_result_t out_data_reg, out_data_next;
    logic         out_valid_reg, out_valid_next;
    fdfp_result_t skid_data_reg, skid_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic         drain;

    // Accept bytes as long as the skid slot is free; results land in the
    // output register or, if that is still waiting, in the skid slot.
    assign s_axis_tready = !skid_valid_reg;
    assign take          = s_axis_tvalid && s_axis_tready;

    // Configuration registers: write only, index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char     <= START_CHAR_RST;
            cfg_reg.end_char       <= END_CHAR_RST;
            cfg_reg.separator_char <= SEPARATOR_CHAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START:     cfg_reg.start_char     <= cfg_data;
                REG_END:       cfg_reg.end_char       <= cfg_data;
                REG_SEPARATOR: cfg_reg.separator_char <= cfg_data;
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    fdfp_core #(
        .MAX_FRAME_CHARS (MAX_FRAME_CHARS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_in   (s_axis_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign drain = out_valid_reg && m_axis_tready;

    // Output register and skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            // input is held, so no new result can arrive; advance the skid
            if (drain)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || drain)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_data_reg.malformed, out_data_reg.values};

    `FDFP_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg,
        "skid slot filled while output register empty")
    `FDFP_ASSERT_ALWAYS(a_result_on_accept, !res_valid || s_axis_tready,
        "result produced while input not ready")
    `FDFP_ASSERT_NEXT(a_skid_hold, skid_valid_reg && !m_axis_tready,
        skid_valid_reg && $stable(skid_data_reg), "skid slot lost while output stalled")

endmodule
